// ===== rtl/core/bsd_pkg.sv =====
package bsd_pkg;

	localparam int FRAME_DEPTH = 64;
	localparam int BYTE_W      = 8;
	localparam int IDX_W       = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
	localparam int CNT_W       = $clog2(FRAME_DEPTH + 1);
	// two store banks: one filling while the other drains
	localparam int NUM_BANKS   = 2;
	localparam int ADDR_W      = IDX_W + 1;
	localparam int MEM_DEPTH   = 2 ** ADDR_W;
	localparam int Q_DEPTH     = NUM_BANKS;
	localparam int Q_PTR_W     = 1;
	localparam int Q_CNT_W     = 2;
	localparam int CFG_IDX_W   = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_MARKER = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_MASK   = 2'd3;

	localparam logic [BYTE_W-1:0] RST_START_MARKER  = 8'hAA;
	localparam logic [BYTE_W-1:0] RST_END_MARKER    = 8'h55;
	localparam logic [BYTE_W-1:0] RST_ESCAPE_MARKER = 8'hDB;
	localparam logic [BYTE_W-1:0] RST_ESCAPE_MASK   = 8'h20;

	typedef struct packed {
		logic             bank;
		logic [CNT_W-1:0] count;
		logic             ovf;
	} desc_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] data;
	} wr_req_t;

endpackage

// ===== rtl/core/bsd_front.sv =====
module bsd_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            rx_valid,
	output logic                            rx_stall,
	input  logic [bsd_pkg::BYTE_W-1:0]      rx_byte,
	input  logic                            cfg_we,
	input  logic [bsd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bsd_pkg::BYTE_W-1:0]      cfg_data,
	input  logic                            q_full,
	output logic                            q_push,
	output bsd_pkg::desc_t                  push_desc,
	output bsd_pkg::wr_req_t                wr_req
);

	typedef enum logic [2:0] {
		MODE_IDLE = 3'b001,
		MODE_DATA = 3'b010,
		MODE_ESC  = 3'b100
	} mode_t;

	mode_t                          mode_q, mode_d;
	logic [bsd_pkg::CNT_W-1:0]      fill_q, fill_d;
	logic                           ovf_q, ovf_d;
	logic                           bank_q, bank_d;
	logic [bsd_pkg::BYTE_W-1:0]     start_q, end_q, esc_q, mask_q;
	logic                           accept;
	logic [bsd_pkg::BYTE_W-1:0]     unesc;
	logic                           store_en;
	logic [bsd_pkg::BYTE_W-1:0]     store_val;

	// both banks pending means the one we would fill is still draining
	assign rx_stall  = q_full;
	assign accept    = rx_valid && !q_full;
	assign unesc     = rx_byte ^ mask_q;
	assign push_desc = '{bank: bank_q, count: fill_q, ovf: ovf_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= bsd_pkg::RST_START_MARKER;
			end_q   <= bsd_pkg::RST_END_MARKER;
			esc_q   <= bsd_pkg::RST_ESCAPE_MARKER;
			mask_q  <= bsd_pkg::RST_ESCAPE_MASK;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bsd_pkg::CFG_START_MARKER:  start_q <= cfg_data;
				bsd_pkg::CFG_END_MARKER:    end_q   <= cfg_data;
				bsd_pkg::CFG_ESCAPE_MARKER: esc_q   <= cfg_data;
				bsd_pkg::CFG_ESCAPE_MASK:   mask_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		mode_d    = mode_q;
		fill_d    = fill_q;
		ovf_d     = ovf_q;
		bank_d    = bank_q;
		q_push    = 1'b0;
		store_en  = 1'b0;
		store_val = rx_byte;
		wr_req    = '{en: 1'b0, addr: {bank_q, fill_q[bsd_pkg::IDX_W-1:0]}, data: rx_byte};
		if (accept) begin
			unique case (mode_q)
				MODE_DATA: begin
					priority if (rx_byte == end_q) begin
						q_push = 1'b1;
						bank_d = ~bank_q;
						mode_d = MODE_IDLE;
						fill_d = '0;
						ovf_d  = 1'b0;
					end else if (rx_byte == esc_q) begin
						mode_d = MODE_ESC;
					end else if (rx_byte == start_q) begin
						fill_d = '0;
						ovf_d  = 1'b0;
					end else begin
						store_en = 1'b1;
					end
				end
				MODE_ESC: begin
					if (unesc == start_q || unesc == end_q || unesc == esc_q) begin
						store_en  = 1'b1;
						store_val = unesc;
						mode_d    = MODE_DATA;
					end else begin
						// bad escape drops the whole frame
						mode_d = MODE_IDLE;
						fill_d = '0;
						ovf_d  = 1'b0;
					end
				end
				MODE_IDLE: begin
					if (rx_byte == start_q) begin
						mode_d = MODE_DATA;
						fill_d = '0;
						ovf_d  = 1'b0;
					end
				end
				default: mode_d = MODE_IDLE;
			endcase
			if (store_en) begin
				if (fill_q < bsd_pkg::CNT_W'(bsd_pkg::FRAME_DEPTH)) begin
					wr_req.en   = 1'b1;
					wr_req.data = store_val;
					fill_d      = fill_q + bsd_pkg::CNT_W'(1);
				end else begin
					ovf_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			fill_q <= '0;
			ovf_q  <= 1'b0;
			bank_q <= 1'b0;
		end else begin
			mode_q <= mode_d;
			fill_q <= fill_d;
			ovf_q  <= ovf_d;
			bank_q <= bank_d;
		end
	end

endmodule

// ===== rtl/core/bsd_queue.sv =====
module bsd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bsd_pkg::desc_t  push_desc,
	input  logic            pop,
	output bsd_pkg::desc_t  head,
	output logic            full,
	output logic            empty
);

	bsd_pkg::desc_t                 entry_q [bsd_pkg::Q_DEPTH];
	logic [bsd_pkg::Q_PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [bsd_pkg::Q_CNT_W-1:0]    cnt_q;

	assign head  = entry_q[rd_ptr_q];
	assign full  = (cnt_q == bsd_pkg::Q_CNT_W'(bsd_pkg::Q_DEPTH));
	assign empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + bsd_pkg::Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + bsd_pkg::Q_PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + bsd_pkg::Q_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - bsd_pkg::Q_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/bsd_back.sv =====
module bsd_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bsd_pkg::wr_req_t            wr_req,
	input  bsd_pkg::desc_t              head,
	input  logic                        q_empty,
	output logic                        q_pop,
	output logic                        frame_valid,
	input  logic                        frame_stall,
	output logic [bsd_pkg::BYTE_W-1:0]  frame_byte,
	output logic                        last_of_frame,
	output logic                        empty_frame,
	output logic                        frame_truncated
);

	typedef enum logic [1:0] {
		B_IDLE = 2'b01,
		B_LOAD = 2'b10
	} bstate_t;

	logic [bsd_pkg::BYTE_W-1:0]     mem [bsd_pkg::MEM_DEPTH];
	logic [bsd_pkg::BYTE_W-1:0]     rd_data_q;
	bstate_t                        state_q, state_d;
	logic [bsd_pkg::IDX_W-1:0]      k_q, k_d, rd_idx;
	logic                           rd_en;
	logic                           out_free;
	logic                           is_last;
	logic                           load;
	logic [bsd_pkg::BYTE_W-1:0]     ld_byte;
	logic                           ld_last, ld_empty;
	logic                           valid_q;

	assign out_free    = !valid_q || !frame_stall;
	assign is_last     = (bsd_pkg::CNT_W'(k_q) + bsd_pkg::CNT_W'(1)) == head.count;
	assign frame_valid = valid_q;

	always_comb begin
		state_d  = state_q;
		k_d      = k_q;
		rd_en    = 1'b0;
		rd_idx   = k_q;
		q_pop    = 1'b0;
		load     = 1'b0;
		ld_byte  = rd_data_q;
		ld_last  = is_last;
		ld_empty = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					if (head.count == '0) begin
						if (out_free) begin
							load     = 1'b1;
							ld_byte  = '0;
							ld_last  = 1'b1;
							ld_empty = 1'b1;
							q_pop    = 1'b1;
						end
					end else begin
						rd_en   = 1'b1;
						rd_idx  = '0;
						k_d     = '0;
						state_d = B_LOAD;
					end
				end
			end
			B_LOAD: begin
				if (out_free) begin
					load = 1'b1;
					if (is_last) begin
						// bank is released only once its last word has left
						q_pop   = 1'b1;
						state_d = B_IDLE;
					end else begin
						k_d    = k_q + bsd_pkg::IDX_W'(1);
						rd_en  = 1'b1;
						rd_idx = k_q + bsd_pkg::IDX_W'(1);
					end
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_req.en) begin
			mem[wr_req.addr] <= wr_req.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[{head.bank, rd_idx}];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			k_q     <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			if (load) begin
				valid_q <= 1'b1;
			end else if (!frame_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_byte      <= ld_byte;
			last_of_frame   <= ld_last;
			empty_frame     <= ld_empty;
			frame_truncated <= head.ovf;
		end
	end

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("descriptor popped from empty queue");

	a_drain_has_desc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_LOAD) |-> !q_empty)
		else $error("draining without a descriptor");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && empty_frame) |-> (last_of_frame && frame_byte == '0))
		else $error("empty frame word malformed");

endmodule

// ===== rtl/core/byte_stuffing_deframer_unit.sv =====
// byte-stuffed frame deframer
// rx channel: rx_valid / rx_stall / rx_byte, one received byte per word.
// frame channel: frame_valid / frame_stall carry frame_byte, last_of_frame,
// empty_frame and frame_truncated, one data byte of a finished frame per word.
// config: cfg_we writes cfg_data into start marker, end marker, escape marker
// or escape mask selected by cfg_index; write only while no frame is in flight.
// an rx byte is taken in the cycle it is offered while rx_stall is low. frames
// are stored in one of two banks; on the end marker the frame is queued and
// the back end drains it at one word per cycle while frame_stall is low, each
// byte going via a read register. while both banks wait to drain, rx_stall
// is high; otherwise the parser keeps filling the other bank.
// a stalled frame word holds; the drain pauses with it and the queue and
// store keep everything, so no byte is lost.
// reset clears the parser to idle, empties the queue and restores the
// register defaults; the store needs no clearing pass.
module byte_stuffing_deframer_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            rx_valid,
	output logic                            rx_stall,
	input  logic [bsd_pkg::BYTE_W-1:0]      rx_byte,
	input  logic                            cfg_we,
	input  logic [bsd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bsd_pkg::BYTE_W-1:0]      cfg_data,
	output logic                            frame_valid,
	input  logic                            frame_stall,
	output logic [bsd_pkg::BYTE_W-1:0]      frame_byte,
	output logic                            last_of_frame,
	output logic                            empty_frame,
	output logic                            frame_truncated
);

	bsd_pkg::desc_t     push_desc, head;
	bsd_pkg::wr_req_t   wr_req;
	logic               q_push, q_pop, q_full, q_empty;

	bsd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_valid),
		.rx_stall  (rx_stall),
		.rx_byte   (rx_byte),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.push_desc (push_desc),
		.wr_req    (wr_req)
	);

	bsd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_desc (push_desc),
		.pop       (q_pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	bsd_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.wr_req          (wr_req),
		.head            (head),
		.q_empty         (q_empty),
		.q_pop           (q_pop),
		.frame_valid     (frame_valid),
		.frame_stall     (frame_stall),
		.frame_byte      (frame_byte),
		.last_of_frame   (last_of_frame),
		.empty_frame     (empty_frame),
		.frame_truncated (frame_truncated)
	);

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("frame queued with both banks pending");

	a_bank_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_req.en && !q_empty) |-> (wr_req.addr[bsd_pkg::ADDR_W-1] != head.bank))
		else $error("store write into the bank being drained");

endmodule
